// File: hw/rtl/zeck_pkg.sv
// Shared types, constants and Fibonacci table for the Zeckendorf encoder.
`default_nettype none
package zeck_pkg;

	localparam int MASK_BITS  = 64;
	localparam int VAL_WIDTH  = 45;
	localparam int TERM_WIDTH = 44;
	localparam int PAIRS      = MASK_BITS / 2;
	localparam int PAIR_W     = $clog2(PAIRS);
	localparam int FIB_IDX_W  = $clog2(MASK_BITS + 1);

	typedef logic [VAL_WIDTH-1:0]  val_t;
	typedef logic [MASK_BITS-1:0]  mask_t;
	typedef logic [TERM_WIDTH-1:0] term_t;
	typedef logic [PAIR_W-1:0]     pair_t;
	typedef val_t fib_tab_t [MASK_BITS+1];

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// entry i holds F(i+2)
	function automatic fib_tab_t fib_table();
		fib_tab_t t;
		t[0] = VAL_WIDTH'(1);
		t[1] = VAL_WIDTH'(2);
		for (int i = 2; i <= MASK_BITS; i++) begin
			t[i] = t[i-1] + t[i-2];
		end
		return t;
	endfunction

	localparam fib_tab_t FIB = fib_table();

endpackage
`default_nettype wire

// File: hw/rtl/zeck_front.sv
// Input stage: takes a value, clamps it to the encodable range, pushes it to the queue.
`default_nettype none
module zeck_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire zeck_pkg::val_t    value,
	input  wire zeck_pkg::q_status_t q_status,
	output logic                   push,
	output zeck_pkg::val_t         push_value
);
	import zeck_pkg::*;

	logic valid_s1;
	val_t value_s1;
	logic accept;

	assign in_stall   = valid_s1 && q_status.full;
	assign accept     = in_valid && !in_stall;
	assign push       = valid_s1 && !q_status.full;
	assign push_value = value_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (value >= FIB[MASK_BITS]) begin
				value_s1 <= FIB[MASK_BITS] - VAL_WIDTH'(1);
			end else begin
				value_s1 <= value;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/zeck_queue.sv
// Two-entry queue between the input stage and the encoding engine.
`default_nettype none
module zeck_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire zeck_pkg::val_t    push_value,
	input  wire logic              pop,
	output zeck_pkg::val_t         pop_value,
	output zeck_pkg::q_status_t    status
);
	import zeck_pkg::*;

	val_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_value    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_value;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/zeck_back.sv
// Greedy Fibonacci subtraction engine, two mask bits per unstalled cycle, output register.
`default_nettype none
module zeck_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire zeck_pkg::q_status_t q_status,
	input  wire zeck_pkg::val_t    pop_value,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output zeck_pkg::mask_t        fib_mask,
	output zeck_pkg::term_t        smallest_term
);
	import zeck_pkg::*;

	logic  busy_q;
	pair_t pair_q;
	val_t  rem_q;
	mask_t mask_q;
	term_t small_q;
	logic  out_valid_q;
	mask_t fib_mask_q;
	term_t smallest_q;

	logic [FIB_IDX_W-1:0] hi_idx;
	logic [FIB_IDX_W-1:0] lo_idx;
	val_t  fib_hi;
	val_t  fib_lo;
	logic  take_hi;
	logic  take_lo;
	val_t  rem_nxt;
	mask_t mask_nxt;
	term_t small_nxt;
	logic  finish;
	logic  slot_free;
	logic  advance;

	assign out_valid     = out_valid_q;
	assign fib_mask      = fib_mask_q;
	assign smallest_term = smallest_q;
	assign pop           = !busy_q && !q_status.empty;

	always_comb begin
		hi_idx    = FIB_IDX_W'({pair_q, 1'b1});
		lo_idx    = FIB_IDX_W'({pair_q, 1'b0});
		fib_hi    = FIB[hi_idx];
		fib_lo    = FIB[lo_idx];
		take_hi   = (rem_q >= fib_hi);
		take_lo   = !take_hi && (rem_q >= fib_lo);
		rem_nxt   = rem_q;
		mask_nxt  = mask_q;
		small_nxt = small_q;
		if (take_hi) begin
			rem_nxt   = rem_q - fib_hi;
			mask_nxt  = mask_q | (MASK_BITS'(1) << {pair_q, 1'b1});
			small_nxt = fib_hi[TERM_WIDTH-1:0];
		end else if (take_lo) begin
			rem_nxt   = rem_q - fib_lo;
			mask_nxt  = mask_q | (MASK_BITS'(1) << {pair_q, 1'b0});
			small_nxt = fib_lo[TERM_WIDTH-1:0];
		end
		finish    = busy_q && ((pair_q == '0) || (rem_nxt == '0));
		slot_free = !out_valid_q || !out_stall;
		advance   = busy_q && (!finish || slot_free);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (advance && finish) begin
				busy_q <= 1'b0;
			end
			if (advance && finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rem_q   <= pop_value;
			pair_q  <= PAIR_W'(PAIRS - 1);
			mask_q  <= '0;
			small_q <= '0;
		end else if (advance) begin
			rem_q   <= rem_nxt;
			pair_q  <= pair_q - PAIR_W'(1);
			mask_q  <= mask_nxt;
			small_q <= small_nxt;
		end
		if (advance && finish) begin
			fib_mask_q <= mask_nxt;
			smallest_q <= small_nxt;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/zeckendorf_encoder_top.sv
// Top level of the Zeckendorf encoder.
//
// Input channel: in_valid / in_stall with the 45-bit value. Output channel:
// out_valid / out_stall with fib_mask (bit i means F(i+2) is a term) and
// smallest_term (0 for an input of 0). A transfer happens on a rising edge
// with valid high and stall low. Values of F(66) or more are clamped to F(66)-1.
// The input stage registers and clamps the value, then hands it to a
// two-entry queue; the engine takes one value at a time from the queue and
// tests two Fibonacci terms per cycle, from the top pair down, stopping once
// the remainder reaches zero or the lowest pair is done; its final step waits
// while the output register is stalled. It pops no new item while busy. An
// item passes the input register, the queue, the engine and the output register.
// The result waits in the output register while out_stall is high; the
// engine stops at the final step of any item it holds, and the queue keeps
// accepting input until it is full and the input stage holds a value, then
// in_stall rises. Reset clears all valid flags and the queue; no item is lost or made.
`default_nettype none
module zeckendorf_encoder_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire zeck_pkg::val_t    value,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output zeck_pkg::mask_t        fib_mask,
	output zeck_pkg::term_t        smallest_term
);
	import zeck_pkg::*;

	q_status_t q_status;
	logic      push;
	val_t      push_value;
	logic      pop;
	val_t      pop_value;

	zeck_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.q_status   (q_status),
		.push       (push),
		.push_value (push_value)
	);

	zeck_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_value (push_value),
		.pop        (pop),
		.pop_value  (pop_value),
		.status     (q_status)
	);

	zeck_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_status      (q_status),
		.pop_value     (pop_value),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.fib_mask      (fib_mask),
		.smallest_term (smallest_term)
	);

endmodule
`default_nettype wire

// File: hw/rtl/zeck_checker.sv
// Port-level checks for the Zeckendorf encoder, bound to the top level.
`default_nettype none
module zeck_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire zeck_pkg::val_t    value,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire zeck_pkg::mask_t   fib_mask,
	input  wire zeck_pkg::term_t   smallest_term
);
	import zeck_pkg::*;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(value))
		else $error("stalled input transfer changed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(fib_mask) && $stable(smallest_term))
		else $error("stalled result changed");

	a_no_neighbors: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((fib_mask & (fib_mask >> 1)) == '0))
		else $error("neighboring Fibonacci terms in mask");

	a_zero_term: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (fib_mask == '0) |-> (smallest_term == '0))
		else $error("nonzero smallest term for empty mask");

	a_nonzero_term: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (fib_mask != '0) |-> (smallest_term != '0))
		else $error("zero smallest term for nonempty mask");

endmodule

bind zeckendorf_encoder_top zeck_checker u_zeck_checker (.*);
`default_nettype wire
